[src/tfpf_pkg.sv]
// tfpf_pkg: shared types, constants and helpers of the tlv field path finder
// used by the channel interfaces and every module of the block

package tfpf_pkg;

  localparam int MAX_PATH_DEPTH = 4;
  localparam int NUM_PATH_TYPES = 4;
  localparam int LEVEL_W = (MAX_PATH_DEPTH > 1) ? $clog2(MAX_PATH_DEPTH) : 1;
  localparam int DEPTH_W = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] ID_INVALID = 16'hFFFF;
  localparam logic [15:0] TYPE_MASK = 16'hFFF0;
  localparam logic [3:0] NIB_LEN1 = 4'hD;
  localparam logic [3:0] NIB_LEN2 = 4'hE;
  localparam logic [3:0] NIB_LEN4 = 4'hF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BUFFER_LENGTH = 3'd0,
    REG_PATH_DEPTH    = 3'd1,
    REG_PATH_TYPE_0   = 3'd2,
    REG_PATH_TYPE_1   = 3'd3,
    REG_PATH_TYPE_2   = 3'd4,
    REG_PATH_TYPE_3   = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_HDR0  = 3'd1,
    PH_HDR1  = 3'd2,
    PH_LEN   = 3'd3,
    PH_SKIP  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [31:0]                     buffer_length;
    logic [DEPTH_W-1:0]              path_depth;
    logic [NUM_PATH_TYPES-1:0][15:0] path_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } byte_item_t;

  function automatic logic [DEPTH_W-1:0] eff_depth(input logic [DEPTH_W-1:0] depth);
    logic [DEPTH_W-1:0] lim;
    lim = DEPTH_W'(MAX_PATH_DEPTH);
    return (depth > lim) ? lim : depth;
  endfunction

  // masked path type of a level, zero beyond the configured types
  function automatic logic [15:0] path_want(input cfg_t c, input logic [LEVEL_W-1:0] lvl);
    logic [15:0] want;
    want = '0;
    for (int i = 0; i < NUM_PATH_TYPES; i++) begin
      if (32'(lvl) == 32'(i)) begin
        want = c.path_type[i] & TYPE_MASK;
      end
    end
    return want;
  endfunction

endpackage

[src/tfpf_ifs.sv]
// tfpf channel interfaces: byte stream, result and configuration write
// depends on tfpf_pkg for widths and types

interface tfpf_byte_if import tfpf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, byte_value, last_byte, input ready);
  modport sink (input valid, byte_value, last_byte, output ready);
endinterface

interface tfpf_result_if import tfpf_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] content_offset;
  logic [31:0] content_size;

  modport source (output valid, status, content_offset, content_size, input ready);
  modport sink (input valid, status, content_offset, content_size, output ready);
endinterface

interface tfpf_cfg_if import tfpf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/tfpf_cfg_regs.sv]
// tfpf_cfg_regs: configuration register file, one write word per cycle
// depends on tfpf_pkg and tfpf_cfg_if

module tfpf_cfg_regs import tfpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tfpf_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.buffer_length <= '0;
      regs.path_depth    <= DEPTH_W'(1);
      regs.path_type     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BUFFER_LENGTH: regs.buffer_length <= cfg.data[31:0];
        REG_PATH_DEPTH:    regs.path_depth <= cfg.data[DEPTH_W-1:0];
        REG_PATH_TYPE_0:   regs.path_type[0] <= cfg.data[15:0];
        REG_PATH_TYPE_1:   regs.path_type[1] <= cfg.data[15:0];
        REG_PATH_TYPE_2:   regs.path_type[2] <= cfg.data[15:0];
        REG_PATH_TYPE_3:   regs.path_type[3] <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

endmodule

[src/tfpf_in_stage.sv]
// tfpf_in_stage: input register between the byte channel and the parser
// depends on tfpf_pkg and tfpf_byte_if

module tfpf_in_stage import tfpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tfpf_byte_if.sink  stream,
  output logic       item_valid,
  output byte_item_t item,
  input  logic       item_ready
);

  assign stream.ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (stream.ready) begin
      item_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      item.byte_value <= stream.byte_value;
      item.last_byte  <= stream.last_byte;
    end
  end

endmodule

[src/tfpf_parser.sv]
// tfpf_parser: per-word tlv parse step, path match and result register
// depends on tfpf_pkg and tfpf_result_if

module tfpf_parser import tfpf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          item_valid,
  input  byte_item_t    item,
  output logic          item_ready,
  tfpf_result_if.source result
);

  phase_t             phase, phase_next;
  logic [15:0]        id_acc, id_next;
  logic [31:0]        len_acc, len_next;
  logic [2:0]         len_left, len_left_next;
  logic [31:0]        region, region_next;
  logic [31:0]        field, field_next;
  logic [LEVEL_W-1:0] level, level_next;
  logic [31:0]        pos, pos_next;
  logic               decided, decided_next;
  logic               match_f, match_next;
  logic [31:0]        found_offset, found_offset_next;
  logic [31:0]        found_size, found_size_next;

  logic               fire;
  logic               take_last;

  assign item_ready = !item.last_byte || !result.valid || result.ready;
  assign fire = item_valid && item_ready;
  assign take_last = fire && item.last_byte;

  always_comb begin
    phase_t             cur_phase;
    logic [31:0]        cur_region;
    logic [31:0]        cur_pos;
    logic [LEVEL_W-1:0] cur_level;
    logic [DEPTH_W-1:0] eff;
    logic [31:0]        region_dec;
    logic [31:0]        pos_inc;
    logic [15:0]        id_full;
    logic [3:0]         nib;
    logic [2:0]         extra;
    logic               hd_go;
    logic [31:0]        hd_len;
    logic [DEPTH_W:0]   lvl_plus;

    phase_next        = phase;
    id_next           = id_acc;
    len_next          = len_acc;
    len_left_next     = len_left;
    region_next       = region;
    field_next        = field;
    level_next        = level;
    pos_next          = pos;
    decided_next      = decided;
    match_next        = match_f;
    found_offset_next = found_offset;
    found_size_next   = found_size;

    eff        = eff_depth(cfg.path_depth);
    cur_phase  = phase;
    cur_region = region;
    cur_pos    = pos;
    cur_level  = level;
    if (phase == PH_START) begin
      cur_phase  = PH_HDR0;
      cur_region = cfg.buffer_length;
      cur_pos    = '0;
      cur_level  = '0;
    end
    region_dec = cur_region - 32'd1;
    pos_inc    = cur_pos + 32'd1;
    id_full    = {id_acc[15:8], item.byte_value};
    nib        = id_full[3:0];
    case (nib)
      NIB_LEN1: extra = 3'd1;
      NIB_LEN2: extra = 3'd2;
      NIB_LEN4: extra = 3'd4;
      default:  extra = 3'd0;
    endcase
    hd_go    = 1'b0;
    hd_len   = '0;
    lvl_plus = (DEPTH_W + 1)'(cur_level) + (DEPTH_W + 1)'(1);

    if (!decided) begin
      if (phase == PH_START && (eff == '0 || cfg.buffer_length < 32'd2)) begin
        phase_next   = PH_HDR0;
        region_next  = cfg.buffer_length;
        pos_next     = '0;
        level_next   = '0;
        decided_next = 1'b1;
        match_next   = 1'b0;
      end else begin
        phase_next  = cur_phase;
        region_next = region_dec;
        pos_next    = pos_inc;
        level_next  = cur_level;
        case (cur_phase)
          PH_HDR0: begin
            id_next    = {item.byte_value, 8'h00};
            phase_next = PH_HDR1;
          end
          PH_HDR1: begin
            id_next = id_full;
            if (id_full == ID_INVALID || region_dec < 32'(extra)) begin
              decided_next = 1'b1;
              match_next   = 1'b0;
            end else if (extra == 3'd0) begin
              hd_len   = 32'(nib);
              len_next = 32'(nib);
              hd_go    = 1'b1;
            end else begin
              len_next      = '0;
              len_left_next = extra;
              phase_next    = PH_LEN;
            end
          end
          PH_LEN: begin
            hd_len        = {len_acc[23:0], item.byte_value};
            len_next      = hd_len;
            len_left_next = len_left - 3'd1;
            hd_go         = (len_left == 3'd1);
          end
          default: begin
            field_next = field - 32'd1;
            if (field == 32'd1) begin
              phase_next = PH_HDR0;
            end
          end
        endcase

        if (hd_go) begin
          if (hd_len > region_dec) begin
            decided_next = 1'b1;
            match_next   = 1'b0;
          end else if ((id_next & TYPE_MASK) == path_want(cfg, cur_level)) begin
            if (lvl_plus >= {1'b0, eff}) begin
              decided_next      = 1'b1;
              match_next        = 1'b1;
              found_offset_next = pos_inc;
              found_size_next   = hd_len;
            end else begin
              region_next = hd_len;
              level_next  = cur_level + LEVEL_W'(1);
              phase_next  = PH_HDR0;
            end
          end else if (hd_len == '0) begin
            phase_next = PH_HDR0;
          end else begin
            field_next = hd_len;
            phase_next = PH_SKIP;
          end
        end

        if (!decided_next && phase_next == PH_HDR0 && region_next < 32'd2) begin
          decided_next = 1'b1;
          match_next   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || take_last) begin
      phase    <= PH_START;
      id_acc   <= '0;
      len_acc  <= '0;
      len_left <= '0;
      region   <= '0;
      field    <= '0;
      level    <= '0;
      pos      <= '0;
      decided  <= 1'b0;
      match_f  <= 1'b0;
    end else if (fire) begin
      phase    <= phase_next;
      id_acc   <= id_next;
      len_acc  <= len_next;
      len_left <= len_left_next;
      region   <= region_next;
      field    <= field_next;
      level    <= level_next;
      pos      <= pos_next;
      decided  <= decided_next;
      match_f  <= match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      found_offset <= found_offset_next;
      found_size   <= found_size_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take_last) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      if (!decided_next) begin
        result.status         <= ST_TRUNCATED;
        result.content_offset <= '0;
        result.content_size   <= '0;
      end else if (match_next) begin
        result.status         <= ST_FOUND;
        result.content_offset <= found_offset_next;
        result.content_size   <= found_size_next;
      end else begin
        result.status         <= ST_NOT_FOUND;
        result.content_offset <= '0;
        result.content_size   <= '0;
      end
    end
  end

endmodule

[src/tlv_field_path_finder_unit.sv]
// tlv_field_path_finder_unit: top level of the tlv field path finder
// a result word leaves the result register once the word carrying last_byte is
//   accepted and passes the input register, then the parse step
// throughput: one byte word per cycle; only a last word waits, while a result is held
// reset: synchronous, clears parse state, result register and configuration defaults
// depends on tfpf_pkg, tfpf_ifs, tfpf_cfg_regs, tfpf_in_stage, tfpf_parser

module tlv_field_path_finder_unit import tfpf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  tfpf_cfg_if.sink      cfg,
  tfpf_byte_if.sink     stream,
  tfpf_result_if.source result
);

  cfg_t       cfg_q;
  logic       item_valid;
  byte_item_t item;
  logic       item_ready;

  tfpf_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_q)
  );

  tfpf_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  tfpf_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_q),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .result     (result)
  );

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.last_byte |=> result.valid)
    else $error("last word consumed without a result");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_FOUND |->
      result.content_offset == 32'd0 && result.content_size == 32'd0)
    else $error("offset or size nonzero on a miss");

  a_held_word_kept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("stalled input word lost");

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> item.last_byte && result.valid && !result.ready)
    else $error("parser stalled without a pending result");

endmodule

[verif/tfpf_checker.sv]
// tfpf_checker: watches the configuration, byte and result channels of the
// tlv field path finder, predicts each result word and compares it field by field
// depends on tfpf_pkg and the channel interfaces in tfpf_ifs
`timescale 1ns / 1ps

module tfpf_checker import tfpf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  tfpf_cfg_if    cfg,
  tfpf_byte_if   stream,
  tfpf_result_if result,
  output int     fail_count,
  output int     pending_count,
  output int     checked_count,
  output int     found_count,
  output int     live_bytes
);

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic [31:0] size;
  } finding_t;

  finding_t    pending_findings[$];
  cfg_t        regs;
  phase_t      ph;
  logic [15:0] id_acc;
  logic [31:0] len_acc;
  int          len_left;
  logic [31:0] region_left;
  logic [31:0] field_left;
  logic [31:0] pos;
  int          level;
  bit          decided;
  bit          matched;
  logic [31:0] hit_offset;
  logic [31:0] hit_size;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 20) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic int depth_limit();
    int d;
    d = int'(regs.path_depth);
    return (d > MAX_PATH_DEPTH) ? MAX_PATH_DEPTH : d;
  endfunction

  task automatic give_up();
    decided = 1'b1;
    matched = 1'b0;
  endtask

  task automatic clear_parse();
    ph = PH_START;
    id_acc = '0;
    len_acc = '0;
    len_left = 0;
    region_left = '0;
    field_left = '0;
    pos = '0;
    level = 0;
    decided = 1'b0;
    matched = 1'b0;
    hit_offset = '0;
    hit_size = '0;
  endtask

  task automatic finish_header();
    logic [15:0] want;
    want = (level < NUM_PATH_TYPES) ? (regs.path_type[level] & TYPE_MASK) : 16'h0000;
    if (len_acc > region_left) begin
      give_up();
    end else if ((id_acc & TYPE_MASK) == want) begin
      if (level + 1 >= depth_limit()) begin
        decided = 1'b1;
        matched = 1'b1;
        hit_offset = pos;
        hit_size = len_acc;
      end else begin
        region_left = len_acc;
        level++;
        ph = PH_HDR0;
      end
    end else if (len_acc == 0) begin
      ph = PH_HDR0;
    end else begin
      field_left = len_acc;
      ph = PH_SKIP;
    end
  endtask

  // walks one byte word through the field parser, queues a finding on last_byte
  task automatic parse_byte(input logic [7:0] b, input logic is_last);
    finding_t f;
    int       extra;
    live_bytes++;
    if (!decided) begin
      if (ph == PH_START) begin
        region_left = regs.buffer_length;
        pos = '0;
        level = 0;
        ph = PH_HDR0;
        if (depth_limit() == 0 || region_left < 2) begin
          give_up();
        end
      end
      if (!decided) begin
        region_left = region_left - 1;
        pos = pos + 1;
        case (ph)
          PH_HDR0: begin
            id_acc = {b, 8'h00};
            ph = PH_HDR1;
          end
          PH_HDR1: begin
            id_acc = id_acc | {8'h00, b};
            if (id_acc == ID_INVALID) begin
              give_up();
            end else begin
              case (id_acc[3:0])
                NIB_LEN1: extra = 1;
                NIB_LEN2: extra = 2;
                NIB_LEN4: extra = 4;
                default:  extra = 0;
              endcase
              if (region_left < extra) begin
                give_up();
              end else if (extra == 0) begin
                len_acc = {28'h0, id_acc[3:0]};
                finish_header();
              end else begin
                len_acc = '0;
                len_left = extra;
                ph = PH_LEN;
              end
            end
          end
          PH_LEN: begin
            len_acc = {len_acc[23:0], b};
            len_left--;
            if (len_left == 0) begin
              finish_header();
            end
          end
          default: begin
            field_left = field_left - 1;
            if (field_left == 0) begin
              ph = PH_HDR0;
            end
          end
        endcase
        if (!decided && ph == PH_HDR0 && region_left < 2) begin
          give_up();
        end
      end
    end
    if (is_last) begin
      if (!decided) begin
        f = '{status: ST_TRUNCATED, offset: 32'h0, size: 32'h0};
      end else if (matched) begin
        f = '{status: ST_FOUND, offset: hit_offset, size: hit_size};
      end else begin
        f = '{status: ST_NOT_FOUND, offset: 32'h0, size: 32'h0};
      end
      pending_findings.push_back(f);
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    finding_t want;
    if (rst) begin
      pending_findings.delete();
      regs.buffer_length = '0;
      regs.path_depth = 3'd1;
      regs.path_type = '0;
      clear_parse();
    end else begin
      if (result.valid && result.ready) begin
        if (pending_findings.size() == 0) begin
          report_mismatch($sformatf("unexpected result word, status %0d", result.status));
        end else begin
          want = pending_findings.pop_front();
          checked_count++;
          if (want.status == ST_FOUND) begin
            found_count++;
          end
          if (result.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", result.status, want.status));
          end
          if (result.content_offset !== want.offset) begin
            report_mismatch($sformatf("content_offset %h, expected %h",
                                      result.content_offset, want.offset));
          end
          if (result.content_size !== want.size) begin
            report_mismatch($sformatf("content_size %h, expected %h",
                                      result.content_size, want.size));
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_BUFFER_LENGTH: regs.buffer_length = cfg.data;
          REG_PATH_DEPTH:    regs.path_depth = cfg.data[DEPTH_W-1:0];
          REG_PATH_TYPE_0:   regs.path_type[0] = cfg.data[15:0];
          REG_PATH_TYPE_1:   regs.path_type[1] = cfg.data[15:0];
          REG_PATH_TYPE_2:   regs.path_type[2] = cfg.data[15:0];
          REG_PATH_TYPE_3:   regs.path_type[3] = cfg.data[15:0];
          default: ;
        endcase
      end
      if (stream.valid && stream.ready) begin
        parse_byte(stream.byte_value, stream.last_byte);
      end
    end
    pending_count = pending_findings.size();
  end

endmodule

[verif/tb.sv]
// tb: stimulus and verdict for tlv_field_path_finder_unit; builds nested field
// buffers for random search paths and leaves prediction to tfpf_checker
// depends on tfpf_pkg, tfpf_ifs, tfpf_checker and the block itself
`timescale 1ns / 1ps

module tb import tfpf_pkg::*;;

  localparam int ITEM_BUDGET = 1550;
  localparam logic [CFG_INDEX_W-1:0] UNUSED_REG_INDEX = 3'd6;

  logic clk = 1'b0;
  logic rst;

  always #6 clk = ~clk;

  tfpf_cfg_if    cfg_ch ();
  tfpf_byte_if   byte_ch ();
  tfpf_result_if res_ch ();

  tlv_field_path_finder_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .stream (byte_ch),
    .result (res_ch)
  );

  int fail_count;
  int pending_count;
  int checked_count;
  int found_count;
  int live_bytes;

  tfpf_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_ch),
    .stream        (byte_ch),
    .result        (res_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .found_count   (found_count),
    .live_bytes    (live_bytes)
  );

  int send_idle_pct = 0;
  int stall_pct = 0;
  int buffers_sent = 0;
  int reg_writes = 0;
  int setting_count = 0;

  cfg_t       plan;
  logic [7:0] frame[$];
  bit         frame_fixed[$];
  logic [7:0] stage[$];
  bit         stage_fixed[$];

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.byte_value <= value;
    byte_ch.last_byte <= is_last;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  task automatic send_hex(input logic [63:0] pattern, input int count);
    for (int i = count - 1; i >= 0; i--) begin
      send_byte(pattern[8*i +: 8], i == 0);
    end
    buffers_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    reg_writes++;
  endtask

  // registers change only once every result word is back and the pipe has drained
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic stage_byte(input logic [7:0] value, input bit is_header);
    stage.push_back(value);
    stage_fixed.push_back(is_header);
  endtask

  task automatic stage_header(input logic [11:0] kind, input logic [31:0] len);
    int         pick;
    logic [3:0] nib;
    pick = $urandom_range(3);
    if (len <= 12 && pick != 0) nib = len[3:0];
    else if (len <= 255 && pick != 1) nib = NIB_LEN1;
    else if (len <= 65535 && pick != 2) nib = NIB_LEN2;
    else nib = NIB_LEN4;
    stage_byte(kind[11:4], 1'b1);
    stage_byte({kind[3:0], nib}, 1'b1);
    case (nib)
      NIB_LEN1: stage_byte(len[7:0], 1'b1);
      NIB_LEN2: begin
        stage_byte(len[15:8], 1'b1);
        stage_byte(len[7:0], 1'b1);
      end
      NIB_LEN4: begin
        stage_byte(len[31:24], 1'b1);
        stage_byte(len[23:16], 1'b1);
        stage_byte(len[15:8], 1'b1);
        stage_byte(len[7:0], 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic stage_sibling(input logic [11:0] avoid);
    logic [11:0] kind;
    logic [31:0] len;
    kind = 12'($urandom);
    while (kind == avoid || kind == 12'hFFF) kind = 12'($urandom);
    len = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 6);
    stage_header(kind, len);
    repeat (len) stage_byte(8'($urandom), 1'b0);
  endtask

  // nests a matching field per level, innermost first, with unrelated fields around it
  task automatic build_frame(input int levels);
    logic [11:0] kind;
    int          n;
    frame.delete();
    frame_fixed.delete();
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    repeat (n) begin
      frame.push_back(8'($urandom));
      frame_fixed.push_back(1'b0);
    end
    for (int lvl = levels - 1; lvl >= 0; lvl--) begin
      stage.delete();
      stage_fixed.delete();
      kind = plan.path_type[lvl][15:4];
      repeat ($urandom_range(2)) stage_sibling(kind);
      stage_header(kind, frame.size());
      foreach (frame[i]) stage_byte(frame[i], frame_fixed[i]);
      repeat ($urandom_range(1)) stage_sibling(kind);
      frame = stage;
      frame_fixed = stage_fixed;
    end
  endtask

  // same field layout each time, fresh contents, sometimes noise or a broken stream
  task automatic send_buffer();
    logic [7:0] word_q[$];
    int         r;
    int         cut;
    int         at;
    foreach (frame[i]) word_q.push_back(frame_fixed[i] ? frame[i] : 8'($urandom));
    r = $urandom_range(99);
    if (r < 6) begin
      word_q.delete();
      repeat ($urandom_range(1, 24)) word_q.push_back(8'($urandom));
    end else if (r < 12) begin
      at = $urandom_range(word_q.size() - 1);
      word_q[at] = word_q[at] ^ 8'($urandom_range(1, 255));
    end else if (r < 20) begin
      cut = $urandom_range(1, word_q.size());
      while (word_q.size() > cut) void'(word_q.pop_back());
    end else if (r < 26) begin
      repeat ($urandom_range(1, 4)) word_q.push_back(8'($urandom));
    end
    foreach (word_q[i]) send_byte(word_q[i], i == word_q.size() - 1);
    buffers_sent++;
  endtask

  task automatic run_group();
    int          r;
    int          levels;
    logic [2:0]  depth;
    logic [31:0] len;
    r = $urandom_range(19);
    if (r == 0) depth = 3'd0;
    else if (r == 1) depth = 3'($urandom_range(5, 7));
    else depth = 3'($urandom_range(1, 4));
    plan.path_depth = depth;
    for (int k = 0; k < NUM_PATH_TYPES; k++) begin
      if (k > 0 && $urandom_range(4) == 0) begin
        plan.path_type[k] = plan.path_type[k-1] ^ 16'($urandom_range(15));
      end else begin
        plan.path_type[k] = 16'($urandom);
      end
    end
    levels = (depth == 0) ? 1 : (depth > MAX_PATH_DEPTH) ? MAX_PATH_DEPTH : int'(depth);
    build_frame(levels);
    len = frame.size();
    r = $urandom_range(99);
    if (r < 6) len = 32'hFFFF_FFFF;
    else if (r < 10) len = $urandom | 32'h100;
    else if (r < 18) len = len + $urandom_range(1, 3);
    else if (r < 26) len = (len > 3) ? len - $urandom_range(1, 3) : 32'h0;
    wait_idle();
    write_reg(REG_BUFFER_LENGTH, len);
    write_reg(REG_PATH_DEPTH, ($urandom_range(3) == 0) ? ($urandom & ~32'h7) | depth : depth);
    for (int k = 0; k < NUM_PATH_TYPES; k++) begin
      write_reg(REG_PATH_TYPE_0 + 3'(k),
                ($urandom_range(3) == 0) ? {16'($urandom), plan.path_type[k]}
                                          : {16'h0, plan.path_type[k]});
    end
    if ($urandom_range(9) == 0) begin
      write_reg(UNUSED_REG_INDEX + 3'($urandom_range(1)), $urandom);
    end
    cfg_ch.valid <= 1'b0;
    setting_count++;
    repeat ($urandom_range(1, 6)) send_buffer();
  endtask

  initial begin
    int target;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    byte_ch.valid <= 1'b0;
    byte_ch.byte_value <= '0;
    byte_ch.last_byte <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: empty buffer region
    send_hex(64'h00, 1);
    wait_idle();
    write_reg(REG_BUFFER_LENGTH, 32'hFFFF_FFFF);
    write_reg(REG_PATH_TYPE_0, 32'h0000_123F);
    cfg_ch.valid <= 1'b0;
    send_hex(64'h123F_FFFF_FFF0, 6);
    send_hex(64'hFFFF, 2);
    send_hex(64'h123F_FFFF_FFFF, 6);
    send_hex(64'h12, 1);
    wait_idle();
    write_reg(REG_BUFFER_LENGTH, 32'd3);
    write_reg(REG_PATH_TYPE_0, 32'h0000_1230);
    cfg_ch.valid <= 1'b0;
    send_hex(64'h77_7000, 3);
    wait_idle();
    write_reg(REG_BUFFER_LENGTH, 32'd8);
    write_reg(REG_PATH_DEPTH, 32'd7);
    write_reg(REG_PATH_TYPE_0, 32'h0000_1110);
    write_reg(REG_PATH_TYPE_1, 32'h0000_2220);
    write_reg(REG_PATH_TYPE_2, 32'h0000_3330);
    write_reg(REG_PATH_TYPE_3, 32'h0000_4440);
    cfg_ch.valid <= 1'b0;
    send_hex(64'h1116_2224_3332_4440, 8);
    setting_count = 4;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      target = live_bytes + ITEM_BUDGET / 4;
      while (live_bytes < target) run_group();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("parsed %0d bytes of %0d buffers under %0d register settings (%0d writes)",
             live_bytes, buffers_sent, setting_count, reg_writes);
    $display("checked %0d result words, %0d of them found", checked_count, found_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d result words outstanding", pending_count);
    $display("== FAIL ==");
    $finish;
  end

endmodule
